### hdl/bzs_pkg.sv
// shared types and constants for the bezier subdivision block
package bzs_pkg;

  localparam int CoordBits = 24;
  localparam int TBits     = 16;
  localparam int IdxBits   = 3;
  localparam int MaxPoints = 7;
  localparam int CntBits   = $clog2(MaxPoints + 1);

  localparam logic CmdQuad  = 1'b0;
  localparam logic CmdCubic = 1'b1;

  localparam logic [CntBits-1:0] NumPtsQuad  = CntBits'(5);
  localparam logic [CntBits-1:0] NumPtsCubic = CntBits'(7);

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [TBits-1:0]            tpar_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    logic   command;
    coord_t p0x;
    coord_t p0y;
    coord_t p1x;
    coord_t p1y;
    coord_t p2x;
    coord_t p2y;
    coord_t p3x;
    coord_t p3y;
    tpar_t  split_at;
  } in_word_t;

  typedef struct packed {
    coord_t             out_x;
    coord_t             out_y;
    logic [IdxBits-1:0] point_index;
    logic               last;
  } out_word_t;

endpackage

### hdl/bzs_lerp_cell.sv
// two stage interpolation cell: a + round((b - a) * t / 2^TBits)
module bzs_lerp_cell
  import bzs_pkg::*;
(
  input  logic   clk_i,
  input  logic   en_i,
  input  coord_t a_i,
  input  coord_t b_i,
  input  tpar_t  t_i,
  output coord_t r_o
);

  localparam int PW = CoordBits + TBits + 2;
  localparam logic signed [PW-1:0] Half = PW'(1) <<< (TBits - 1);

  logic signed [CoordBits:0] diff;
  logic signed [TBits:0]     tsg;
  logic signed [PW-1:0]      prod_d, prod_q;
  logic signed [PW-1:0]      sum;
  coord_t                    a_q, r_d, r_q;

  assign diff   = (CoordBits + 1)'(b_i) - (CoordBits + 1)'(a_i);
  assign tsg    = signed'({1'b0, t_i});
  assign prod_d = PW'(diff) * PW'(tsg) + Half;
  assign sum    = PW'(a_q) + (prod_q >>> TBits);
  assign r_d    = sum[CoordBits-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= a_i;
      prod_q <= prod_d;
      r_q    <= r_d;
    end
  end

  assign r_o = r_q;

endmodule

### hdl/bzs_serializer.sv
// shift chain that emits the split points one word at a time
module bzs_serializer
  import bzs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  point_t             pts_i [MaxPoints],
  input  logic [CntBits-1:0] cnt_i,
  output logic               load_ok_o,
  output logic               valid_o,
  input  logic               ready_i,
  output out_word_t          word_o
);

  point_t             pts_q [MaxPoints];
  logic [CntBits-1:0] cnt_d, cnt_q;
  logic [IdxBits-1:0] idx_d, idx_q;
  logic               take;

  assign valid_o   = (cnt_q != '0);
  assign take      = valid_o && ready_i;
  assign load_ok_o = (cnt_q == '0) || ((cnt_q == CntBits'(1)) && ready_i);

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = cnt_i;
      idx_d = '0;
    end else if (take) begin
      cnt_d = cnt_q - CntBits'(1);
      idx_d = idx_q + IdxBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  // each slot takes its neighbor on a shift
  for (genvar i = 0; i < MaxPoints; i++) begin : g_slot
    always_ff @(posedge clk_i) begin
      if (load_i) begin
        pts_q[i] <= pts_i[i];
      end else if (take) begin
        if (i < MaxPoints - 1) begin
          pts_q[i] <= pts_q[(i + 1) % MaxPoints];
        end
      end
    end
  end

  assign word_o.out_x       = pts_q[0].x;
  assign word_o.out_y       = pts_q[0].y;
  assign word_o.point_index = idx_q;
  assign word_o.last        = (cnt_q == CntBits'(1));

endmodule

### hdl/bezier_subdivide.sv
// top level of the de casteljau bezier subdivision block
//
// Splits a quadratic or cubic Bezier curve at t = split_at / 2^16 and emits
// the control points of both halves, shared split point once: five words for
// a quadratic, seven for a cubic, with point_index counting from zero and
// last set on the final word. Each input word runs through three levels of
// interpolation cells before its points are loaded into the output shift
// chain, and the pipeline stalls while that chain cannot take them. The
// output shift chain sends one point per cycle while out_ready_i is high,
// which limits the sustained input rate; a new input word is taken while the
// previous one is still being sent.
module bezier_subdivide
  import bzs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int Stages = 6;

  typedef struct packed {
    logic   cubic;
    tpar_t  t;
    point_t p0;
    point_t p2;
    point_t p3;
  } side_t;

  logic          en;
  logic          ser_ok;
  logic          load;
  logic [Stages-1:0] v_q;
  side_t         side_q [Stages];
  side_t         side_d;

  coord_t        pin [4][2];
  coord_t        l1 [3][2];
  coord_t        l2 [2][2];
  coord_t        l3 [2];
  coord_t        l1_dly_q [4][3][2];
  coord_t        l2_dly_q [2][2][2];
  point_t        pts [MaxPoints];
  logic [CntBits-1:0] cnt;
  side_t         last_side;

  assign load       = v_q[Stages-1] && ser_ok;
  assign en         = !v_q[Stages-1] || ser_ok;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[Stages-2:0], in_valid_i};
    end
  end

  assign pin[0][0] = in_word_i.p0x;
  assign pin[0][1] = in_word_i.p0y;
  assign pin[1][0] = in_word_i.p1x;
  assign pin[1][1] = in_word_i.p1y;
  assign pin[2][0] = in_word_i.p2x;
  assign pin[2][1] = in_word_i.p2y;
  assign pin[3][0] = in_word_i.p3x;
  assign pin[3][1] = in_word_i.p3y;

  always_comb begin
    side_d.cubic = (in_word_i.command == CmdCubic);
    side_d.t     = in_word_i.split_at;
    side_d.p0    = '{x: in_word_i.p0x, y: in_word_i.p0y};
    side_d.p2    = '{x: in_word_i.p2x, y: in_word_i.p2y};
    side_d.p3    = '{x: in_word_i.p3x, y: in_word_i.p3y};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int i = 1; i < Stages; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  for (genvar d = 0; d < 2; d++) begin : g_dim
    for (genvar k = 0; k < 3; k++) begin : g_l1
      bzs_lerp_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .a_i   (pin[k][d]),
        .b_i   (pin[k+1][d]),
        .t_i   (in_word_i.split_at),
        .r_o   (l1[k][d])
      );
    end
    for (genvar k = 0; k < 2; k++) begin : g_l2
      bzs_lerp_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .a_i   (l1[k][d]),
        .b_i   (l1[k+1][d]),
        .t_i   (side_q[1].t),
        .r_o   (l2[k][d])
      );
    end
    bzs_lerp_cell u_l3 (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (l2[0][d]),
      .b_i   (l2[1][d]),
      .t_i   (side_q[3].t),
      .r_o   (l3[d])
    );
  end

  // keep earlier levels aligned with the last level
  always_ff @(posedge clk_i) begin
    if (en) begin
      l1_dly_q[0] <= l1;
      for (int i = 1; i < 4; i++) begin
        l1_dly_q[i] <= l1_dly_q[i-1];
      end
      l2_dly_q[0] <= l2;
      l2_dly_q[1] <= l2_dly_q[0];
    end
  end

  assign last_side = side_q[Stages-1];

  always_comb begin
    pts[0] = last_side.p0;
    pts[1] = '{x: l1_dly_q[3][0][0], y: l1_dly_q[3][0][1]};
    pts[2] = '{x: l2_dly_q[1][0][0], y: l2_dly_q[1][0][1]};
    pts[5] = '{x: l1_dly_q[3][2][0], y: l1_dly_q[3][2][1]};
    pts[6] = last_side.p3;
    if (last_side.cubic) begin
      pts[3] = '{x: l3[0], y: l3[1]};
      pts[4] = '{x: l2_dly_q[1][1][0], y: l2_dly_q[1][1][1]};
      cnt    = NumPtsCubic;
    end else begin
      pts[3] = '{x: l1_dly_q[3][1][0], y: l1_dly_q[3][1][1]};
      pts[4] = last_side.p2;
      cnt    = NumPtsQuad;
    end
  end

  bzs_serializer u_ser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .pts_i     (pts),
    .cnt_i     (cnt),
    .load_ok_o (ser_ok),
    .valid_o   (out_valid_o),
    .ready_i   (out_ready_i),
    .word_o    (out_word_o)
  );

endmodule
